### rtl/core/local_rgb_mean_covariance_3x3_assert.svh
// assertion macros for the local rgb mean and covariance block
`ifndef LOCAL_RGB_MEAN_COVARIANCE_3X3_ASSERT_SVH
`define LOCAL_RGB_MEAN_COVARIANCE_3X3_ASSERT_SVH

`ifndef SYNTHESIS

// condition now implies consequence now
`define LRMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition now implies consequence on the next edge
`define LRMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LRMC_ASSERT_NOW(lbl, ante, cons, msg)
`define LRMC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/core/lrmc_pkg.sv
// types, constants and helpers for the local rgb mean and covariance block
package lrmc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = 11;
  localparam int EPS_W  = 20;
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 2;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = 12;
  localparam int PROD_W = 2 * CH_W;
  localparam int PSUM_W = 20;
  localparam int VAR_W  = 23;
  localparam int COV_W  = 24;

  localparam int NTAP  = 9;
  localparam int NPAIR = 6;

  // channel pairs in output order: rr, rg, rb, gg, gb, bb
  localparam int PAIR_A [NPAIR] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_B [NPAIR] = '{0, 1, 2, 1, 2, 2};

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t r0;
    pixel_t r1;
    pixel_t r2;
  } column_t;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_EPS_SCALED   = 2'd2
  } cfg_reg_t;

  // results one pixel can produce, in delivery order
  typedef enum logic [1:0] {
    JOB_MAIN      = 2'd0,
    JOB_EDGE      = 2'd1,
    JOB_LAST_MAIN = 2'd2,
    JOB_LAST_EDGE = 2'd3
  } job_t;

  typedef struct packed {
    logic c_ge1;
    logic c_eq1;
    logic c_last;
    logic r_ge1;
    logic r_eq1;
    logic r_last;
  } pos_t;

  function automatic logic [COL_W-1:0] last_col(input logic [DIM_W-1:0] v);
    if (v < 3) begin
      return COL_W'(2);
    end else if (int'(v) > MAX_WIDTH) begin
      return COL_W'(MAX_WIDTH - 1);
    end else begin
      return COL_W'(v - 1'b1);
    end
  endfunction

  function automatic logic [ROW_W-1:0] last_row(input logic [DIM_W-1:0] v);
    if (v < 3) begin
      return ROW_W'(2);
    end else if (int'(v) > MAX_HEIGHT) begin
      return ROW_W'(MAX_HEIGHT - 1);
    end else begin
      return ROW_W'(v - 1'b1);
    end
  endfunction

  function automatic pixel_t pick_row(input column_t col, input logic [1:0] sel);
    case (sel)
      2'd0:    return col.r0;
      2'd1:    return col.r1;
      default: return col.r2;
    endcase
  endfunction

endpackage

### rtl/core/local_rgb_mean_covariance_3x3.sv
// 3x3 window rgb sums and scaled local color covariance, reflect-101 borders
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  pixel   | in_valid, in_stall, red, green, blue  | in
//  result  | out_valid, out_stall, sum_*, cov_*,   | out
//          | frame_last                            |
//  config  | cfg_we, cfg_index, cfg_data           | in
//
// one pixel a cycle while in_stall is low; a window's result passes the input, window,
// s1 to s4 and output registers; row-0 pixels give no result, the last pixel of a later row
// and each pixel past column 0 of the last row give two, the frame's last pixel four
// the window stage issues one result a cycle while s1 is ready, so such a pixel holds the
// input until its results issue; out_stall backs up stage by stage, bubbles squeeze out
// rst clears handshake, counters and config, not the line store: rows are written before read
`include "local_rgb_mean_covariance_3x3_assert.svh"

module local_rgb_mean_covariance_3x3
  import lrmc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CH_W-1:0]         red,
  input  logic [CH_W-1:0]         green,
  input  logic [CH_W-1:0]         blue,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SUM_W-1:0]        sum_red,
  output logic [SUM_W-1:0]        sum_green,
  output logic [SUM_W-1:0]        sum_blue,
  output logic [VAR_W-1:0]        cov_rr,
  output logic signed [COV_W-1:0] cov_rg,
  output logic signed [COV_W-1:0] cov_rb,
  output logic [VAR_W-1:0]        cov_gg,
  output logic signed [COV_W-1:0] cov_gb,
  output logic [VAR_W-1:0]        cov_bb,
  output logic                    frame_last
);

  // configuration
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [EPS_W-1:0] eps_scaled;

  // position of the next pixel
  logic [COL_W-1:0] column_counter;
  logic [ROW_W-1:0] row_counter;
  logic [COL_W-1:0] col_max;
  logic [ROW_W-1:0] row_max;
  logic             col_last;
  logic             row_last;

  // input stage
  logic             in_acc;
  logic             a_valid;
  logic             a_ready;
  pixel_t           a_px;
  logic [COL_W-1:0] a_c;
  pos_t             a_pos;

  // line store: {row above, two rows above}
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_rd;

  // window stage
  column_t    win0;
  column_t    win1;
  column_t    win2;
  logic [3:0] pending;
  logic       left_sel;
  logic       top_sel;
  logic       b_ready;
  logic       b_take;
  logic       issue;
  job_t       job;
  logic [3:0] issue_mask;
  logic [3:0] new_mask;

  // selection for the arithmetic pipe
  column_t    left_col;
  column_t    sel_c0;
  column_t    sel_c1;
  column_t    sel_c2;
  logic       mirror;
  logic       final_pass;
  logic [1:0] ridx0;
  logic [1:0] ridx1;
  logic [1:0] ridx2;
  pixel_t     tap_next [NTAP];

  // arithmetic pipe
  logic              s1_valid;
  logic              s1_ready;
  pixel_t            s1_px [NTAP];
  logic              s1_last;
  logic              s2_valid;
  logic              s2_ready;
  logic [PROD_W-1:0] s2_prod [NTAP][NPAIR];
  logic [SUM_W-1:0]  s2_sum [3];
  logic              s2_last;
  logic              s3_valid;
  logic              s3_ready;
  logic [PSUM_W-1:0] s3_p [NPAIR];
  logic [SUM_W-1:0]  s3_sum [3];
  logic              s3_last;
  logic              s4_valid;
  logic              s4_ready;
  logic [VAR_W-1:0]  s4_m9 [NPAIR];
  logic [VAR_W-1:0]  s4_ss [NPAIR];
  logic [SUM_W-1:0]  s4_sum [3];
  logic              s4_last;
  logic              o_ready;
  logic [SUM_W-1:0]  out_sum [3];
  logic [COV_W-1:0]  out_cov [NPAIR];

  logic [PROD_W-1:0]  prod_next [NTAP][NPAIR];
  logic [SUM_W-1:0]   sum_next [3];
  logic [PSUM_W-1:0]  p_next [NPAIR];
  logic [VAR_W-1:0]   m9_next [NPAIR];
  logic [VAR_W-1:0]   ss_next [NPAIR];
  logic [2*SUM_W-1:0] ss_full [NPAIR];
  logic [COV_W-1:0]   cov_next [NPAIR];

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
      eps_scaled   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_EPS_SCALED:   eps_scaled   <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign col_max  = last_col(image_width);
  assign row_max  = last_row(image_height);
  assign col_last = (column_counter == col_max);
  assign row_last = (row_counter == row_max);

  // ---------------------------------------------------------------- counters
  assign a_ready  = !a_valid || b_ready;
  assign in_stall = !a_ready;
  assign in_acc   = in_valid && a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
    end else if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      // a geometry change restarts the frame
      column_counter <= '0;
      row_counter    <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        column_counter <= '0;
        row_counter    <= row_last ? '0 : row_counter + 1'b1;
      end else begin
        column_counter <= column_counter + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_px         <= {blue, green, red};
      a_c          <= column_counter;
      a_pos.c_ge1  <= (column_counter != '0);
      a_pos.c_eq1  <= (column_counter == COL_W'(1));
      a_pos.c_last <= col_last;
      a_pos.r_ge1  <= (row_counter != '0);
      a_pos.r_eq1  <= (row_counter == ROW_W'(1));
      a_pos.r_last <= row_last;
    end
  end

  // read at beat time, shift the column in when the window stage takes it
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_rd <= line_mem[column_counter];
    end
    if (b_take) begin
      line_mem[a_c] <= {a_px, mem_rd[2*PIX_W-1:PIX_W]};
    end
  end

  // ---------------------------------------------------------------- window stage
  always_comb begin
    job = JOB_MAIN;
    if (pending[JOB_MAIN]) begin
      job = JOB_MAIN;
    end else if (pending[JOB_EDGE]) begin
      job = JOB_EDGE;
    end else if (pending[JOB_LAST_MAIN]) begin
      job = JOB_LAST_MAIN;
    end else begin
      job = JOB_LAST_EDGE;
    end
  end

  assign issue      = (pending != '0) && s1_ready;
  assign issue_mask = issue ? (4'b0001 << job) : 4'b0000;
  assign b_ready    = ((pending & ~issue_mask) == '0);
  assign b_take     = a_valid && b_ready;

  always_comb begin
    new_mask                = '0;
    new_mask[JOB_MAIN]      = a_pos.r_ge1 && a_pos.c_ge1;
    new_mask[JOB_EDGE]      = a_pos.r_ge1 && a_pos.c_last;
    new_mask[JOB_LAST_MAIN] = a_pos.r_last && a_pos.c_ge1;
    new_mask[JOB_LAST_EDGE] = a_pos.r_last && a_pos.c_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (b_take) begin
      pending <= new_mask;
    end else begin
      pending <= pending & ~issue_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      win0     <= win1;
      win1     <= win2;
      win2.r0  <= mem_rd[PIX_W-1:0];
      win2.r1  <= mem_rd[2*PIX_W-1:PIX_W];
      win2.r2  <= a_px;
      left_sel <= a_pos.c_eq1;
      top_sel  <= a_pos.r_eq1;
    end
  end

  // right edge mirrors the center-left column, bottom edge mirrors row above
  assign mirror     = (job == JOB_EDGE) || (job == JOB_LAST_EDGE);
  assign final_pass = (job == JOB_LAST_MAIN) || (job == JOB_LAST_EDGE);
  assign left_col   = left_sel ? win2 : win0;
  assign sel_c0     = mirror ? win1 : left_col;
  assign sel_c1     = mirror ? win2 : win1;
  assign sel_c2     = mirror ? win1 : win2;
  assign ridx0      = final_pass ? 2'd1 : (top_sel ? 2'd2 : 2'd0);
  assign ridx1      = final_pass ? 2'd2 : 2'd1;
  assign ridx2      = final_pass ? 2'd1 : 2'd2;

  always_comb begin
    tap_next[0] = pick_row(sel_c0, ridx0);
    tap_next[1] = pick_row(sel_c0, ridx1);
    tap_next[2] = pick_row(sel_c0, ridx2);
    tap_next[3] = pick_row(sel_c1, ridx0);
    tap_next[4] = pick_row(sel_c1, ridx1);
    tap_next[5] = pick_row(sel_c1, ridx2);
    tap_next[6] = pick_row(sel_c2, ridx0);
    tap_next[7] = pick_row(sel_c2, ridx1);
    tap_next[8] = pick_row(sel_c2, ridx2);
  end

  // ---------------------------------------------------------------- pipe control
  assign o_ready  = !out_valid || !out_stall;
  assign s4_ready = !s4_valid || o_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= (pending != '0);
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (o_ready)  out_valid <= s4_valid;
    end
  end

  // ---------------------------------------------------------------- arithmetic
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum_next[a] = '0;
      for (int i = 0; i < NTAP; i++) begin
        sum_next[a] = sum_next[a] + SUM_W'(s1_px[i][CH_W*a +: CH_W]);
      end
    end
    for (int i = 0; i < NTAP; i++) begin
      for (int k = 0; k < NPAIR; k++) begin
        prod_next[i][k] = PROD_W'(s1_px[i][CH_W*PAIR_A[k] +: CH_W])
                        * PROD_W'(s1_px[i][CH_W*PAIR_B[k] +: CH_W]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NPAIR; k++) begin
      p_next[k] = '0;
      for (int i = 0; i < NTAP; i++) begin
        p_next[k] = p_next[k] + PSUM_W'(s2_prod[i][k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NPAIR; k++) begin
      m9_next[k] = VAR_W'({s3_p[k], 3'b000}) + VAR_W'(s3_p[k]);
      ss_full[k] = (2*SUM_W)'(s3_sum[PAIR_A[k]]) * (2*SUM_W)'(s3_sum[PAIR_B[k]]);
      ss_next[k] = ss_full[k][VAR_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < NPAIR; k++) begin
      cov_next[k] = COV_W'({1'b0, s4_m9[k]}) - COV_W'({1'b0, s4_ss[k]});
      // epsilon only on the diagonal terms
      if (PAIR_A[k] == PAIR_B[k]) begin
        cov_next[k] = cov_next[k] + COV_W'(eps_scaled);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_px   <= tap_next;
      s1_last <= (job == JOB_LAST_EDGE);
    end
    if (s2_ready) begin
      s2_prod <= prod_next;
      s2_sum  <= sum_next;
      s2_last <= s1_last;
    end
    if (s3_ready) begin
      s3_p    <= p_next;
      s3_sum  <= s2_sum;
      s3_last <= s2_last;
    end
    if (s4_ready) begin
      s4_m9   <= m9_next;
      s4_ss   <= ss_next;
      s4_sum  <= s3_sum;
      s4_last <= s3_last;
    end
    if (o_ready) begin
      out_sum    <= s4_sum;
      out_cov    <= cov_next;
      frame_last <= s4_last;
    end
  end

  assign sum_red   = out_sum[0];
  assign sum_green = out_sum[1];
  assign sum_blue  = out_sum[2];
  assign cov_rr    = out_cov[0][VAR_W-1:0];
  assign cov_rg    = signed'(out_cov[1]);
  assign cov_rb    = signed'(out_cov[2]);
  assign cov_gg    = out_cov[3][VAR_W-1:0];
  assign cov_gb    = signed'(out_cov[4]);
  assign cov_bb    = out_cov[5][VAR_W-1:0];

  // ---------------------------------------------------------------- checks
  `LRMC_ASSERT_NEXT(a_frame_wrap, in_acc && col_last && row_last,
                    (column_counter == '0) && (row_counter == '0),
                    "counters did not wrap after the last pixel of a frame")
  `LRMC_ASSERT_NEXT(a_row0_silent, b_take && !a_pos.r_ge1, pending == '0,
                    "a first-row pixel scheduled a result")
  `LRMC_ASSERT_NOW(a_out_source, $rose(out_valid), $past(s4_valid),
                   "result beat appeared without a multiply stage entry")

endmodule

### tb/tb.sv
// testbench for the 3x3 rgb window sum and scaled covariance block
`timescale 1ns / 1ps

module tb;
  import lrmc_pkg::*;

  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_PIXELS = 190;
  localparam int EDGE_PIXELS   = 12;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    logic [VAR_W-1:0] cov_rr;
    logic [COV_W-1:0] cov_rg;
    logic [COV_W-1:0] cov_rb;
    logic [VAR_W-1:0] cov_gg;
    logic [COV_W-1:0] cov_gb;
    logic [VAR_W-1:0] cov_bb;
    logic             frame_last;
  } window_stats_t;

  class cov_scoreboard;
    pixel_t           prev_row [MAX_WIDTH];
    pixel_t           older_row [MAX_WIDTH];
    pixel_t           win [3][3];
    int               col_pos;
    int               row_pos;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [EPS_W-1:0] eps_reg;
    window_stats_t    expected_q [$];
    int               mismatches;
    int               results_ok;
    int               pixels_seen;

    function new();
      foreach (prev_row[i]) begin
        prev_row[i]  = '0;
        older_row[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos     = 0;
      row_pos     = 0;
      width_reg   = 640;
      height_reg  = 480;
      eps_reg     = '0;
      mismatches  = 0;
      results_ok  = 0;
      pixels_seen = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = val[DIM_W-1:0];
          col_pos   = 0;
          row_pos   = 0;
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = val[DIM_W-1:0];
          col_pos    = 0;
          row_pos    = 0;
        end
        REG_EPS_SCALED: eps_reg = val[EPS_W-1:0];
        default: ;
      endcase
    endfunction

    function int clamp_dim(int v, int hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void queue_expected(window_stats_t res);
      expected_q.insert(expected_q.size(), res);
    endfunction

    // window built from three column picks and three row picks
    function window_stats_t window_result(int csel[3], int rsel[3], logic last_flag);
      int s [3];
      int p [3][3];
      int ch [3];
      pixel_t px;
      window_stats_t res;
      foreach (s[a]) s[a] = 0;
      foreach (p[a, b]) p[a][b] = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          px = win[csel[i]][rsel[j]];
          for (int a = 0; a < 3; a++) ch[a] = int'(px[8*a +: 8]);
          for (int a = 0; a < 3; a++) begin
            s[a] += ch[a];
            for (int b = a; b < 3; b++) p[a][b] += ch[a] * ch[b];
          end
        end
      end
      res.sum_red    = SUM_W'(s[0]);
      res.sum_green  = SUM_W'(s[1]);
      res.sum_blue   = SUM_W'(s[2]);
      res.cov_rr     = VAR_W'(9 * p[0][0] - s[0] * s[0] + int'(eps_reg));
      res.cov_rg     = COV_W'(9 * p[0][1] - s[0] * s[1]);
      res.cov_rb     = COV_W'(9 * p[0][2] - s[0] * s[2]);
      res.cov_gg     = VAR_W'(9 * p[1][1] - s[1] * s[1] + int'(eps_reg));
      res.cov_gb     = COV_W'(9 * p[1][2] - s[1] * s[2]);
      res.cov_bb     = VAR_W'(9 * p[2][2] - s[2] * s[2] + int'(eps_reg));
      res.frame_last = last_flag;
      return res;
    endfunction

    function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      int w;
      int h;
      int c;
      int rw;
      int csel [3];
      int rsel [3];
      logic last_flag;
      w = clamp_dim(int'(width_reg), MAX_WIDTH);
      h = clamp_dim(int'(height_reg), MAX_HEIGHT);
      c = (col_pos >= w) ? 0 : col_pos;
      rw = (row_pos >= h) ? 0 : row_pos;
      pixels_seen++;

      win[0] = win[1];
      win[1] = win[2];
      win[2][0] = older_row[c];
      win[2][1] = prev_row[c];
      win[2][2] = {b, g, r};

      // first pass: output row above; second pass: mirrored last row
      for (int pass = 0; pass < 2; pass++) begin
        if (pass == 0 && rw < 1) continue;
        if (pass == 1 && rw != h - 1) continue;
        if (pass == 0) begin
          rsel = '{(rw == 1) ? 2 : 0, 1, 2};
          last_flag = 1'b0;
        end else begin
          rsel = '{1, 2, 1};
          last_flag = 1'b1;
        end
        if (c >= 1) begin
          csel = '{(c == 1) ? 2 : 0, 1, 2};
          queue_expected(window_result(csel, rsel, 1'b0));
        end
        if (c == w - 1) begin
          csel = '{1, 2, 1};
          queue_expected(window_result(csel, rsel, last_flag));
        end
      end

      older_row[c] = prev_row[c];
      prev_row[c]  = {b, g, r};
      c++;
      if (c >= w) begin
        c = 0;
        rw++;
        if (rw >= h) rw = 0;
      end
      col_pos = c;
      row_pos = rw;
    endfunction

    function void check_result(window_stats_t got);
      window_stats_t want;
      bit bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: sums %0d %0d %0d", got.sum_red, got.sum_green,
                   got.sum_blue);
        return;
      end
      want = expected_q.pop_front();
      bad = (got.sum_red !== want.sum_red) || (got.sum_green !== want.sum_green) ||
            (got.sum_blue !== want.sum_blue) || (got.cov_rr !== want.cov_rr) ||
            (got.cov_rg !== want.cov_rg) || (got.cov_rb !== want.cov_rb) ||
            (got.cov_gg !== want.cov_gg) || (got.cov_gb !== want.cov_gb) ||
            (got.cov_bb !== want.cov_bb) || (got.frame_last !== want.frame_last);
      if (!bad) begin
        results_ok++;
        return;
      end
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d expected: sums %0d %0d %0d cov rr %0d rg %0d rb %0d",
                 results_ok + mismatches, want.sum_red, want.sum_green, want.sum_blue,
                 want.cov_rr, $signed(want.cov_rg), $signed(want.cov_rb));
        $display("  gg %0d gb %0d bb %0d last %0d",
                 want.cov_gg, $signed(want.cov_gb), want.cov_bb, want.frame_last);
        $display("result %0d actual:   sums %0d %0d %0d cov rr %0d rg %0d rb %0d",
                 results_ok + mismatches, got.sum_red, got.sum_green, got.sum_blue,
                 got.cov_rr, $signed(got.cov_rg), $signed(got.cov_rb));
        $display("  gg %0d gb %0d bb %0d last %0d",
                 got.cov_gg, $signed(got.cov_gb), got.cov_bb, got.frame_last);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [CH_W-1:0]         red;
  logic [CH_W-1:0]         green;
  logic [CH_W-1:0]         blue;
  logic                    out_valid;
  logic                    out_stall;
  logic [SUM_W-1:0]        sum_red;
  logic [SUM_W-1:0]        sum_green;
  logic [SUM_W-1:0]        sum_blue;
  logic [VAR_W-1:0]        cov_rr;
  logic signed [COV_W-1:0] cov_rg;
  logic signed [COV_W-1:0] cov_rb;
  logic [VAR_W-1:0]        cov_gg;
  logic signed [COV_W-1:0] cov_gb;
  logic [VAR_W-1:0]        cov_bb;
  logic                    frame_last;

  cov_scoreboard sb = new();
  bit            idling;
  int            cycles;
  int            frames_seen;
  int            writes_done;
  window_stats_t seen;

  local_rgb_mean_covariance_3x3 DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sum_red    (sum_red),
    .sum_green  (sum_green),
    .sum_blue   (sum_blue),
    .cov_rr     (cov_rr),
    .cov_rg     (cov_rg),
    .cov_rb     (cov_rb),
    .cov_gg     (cov_gg),
    .cov_gb     (cov_gb),
    .cov_bb     (cov_bb),
    .frame_last (frame_last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // monitors: register writes, pixel beats and result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        sb.write_reg(cfg_index, cfg_data);
        writes_done++;
      end
      if (in_valid && !in_stall) sb.note_pixel(red, green, blue);
      if (out_valid && !out_stall) begin
        seen.sum_red    = sum_red;
        seen.sum_green  = sum_green;
        seen.sum_blue   = sum_blue;
        seen.cov_rr     = cov_rr;
        seen.cov_rg     = cov_rg;
        seen.cov_rb     = cov_rb;
        seen.cov_gg     = cov_gg;
        seen.cov_gb     = cov_gb;
        seen.cov_bb     = cov_bb;
        seen.frame_last = frame_last;
        sb.check_result(seen);
        if (frame_last) frames_seen++;
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = idling ? gap_len() : 0;
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  end

  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    int gap;
    gap = idling ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed_pixels(input int n);
    for (int i = 0; i < n; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());
  endtask

  // sender holds off until every pending result is out, then lets the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int w;
    int h;
    int n;
    int random_pixels;
    logic [DIM_W-1:0] wv;
    logic [DIM_W-1:0] hv;
    logic [EPS_W-1:0] ev;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    red       = '0;
    green     = '0;
    blue      = '0;
    idling    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // smallest frame, checkerboard of extremes, largest epsilon
    wait_idle();
    write_cfg(REG_IMAGE_WIDTH, CFG_W'(3));
    write_cfg(REG_IMAGE_HEIGHT, CFG_W'(3));
    write_cfg(REG_EPS_SCALED, '1);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++)
        if ((x + y) % 2 == 1) send_pixel(8'hFF, 8'h00, 8'hFF);
        else send_pixel(8'h00, 8'hFF, 8'h00);

    // 4x3 frame, no epsilon, unused register index
    wait_idle();
    write_cfg(REG_IMAGE_WIDTH, CFG_W'(4));
    write_cfg(REG_EPS_SCALED, '0);
    write_cfg(REG_SPARE, '1);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 4; x++)
        send_pixel(((x ^ y) & 1) ? 8'hFF : 8'h00, (y == 2) ? 8'hFF : 8'h00,
                   CH_W'((x + 4 * y) * 21));

    // random frames of small sizes, some cut short by a geometry restart
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      idling = ($urandom_range(0, 3) != 0);
      wv = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 2)) :
                                         DIM_W'($urandom_range(3, 8));
      hv = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 2)) :
                                         DIM_W'($urandom_range(3, 6));
      case ($urandom_range(0, 3))
        0:       ev = '0;
        1:       ev = '1;
        default: ev = EPS_W'($urandom);
      endcase
      wait_idle();
      write_cfg(REG_IMAGE_WIDTH, {CFG_W'($urandom_range(0, 511)) << DIM_W} | CFG_W'(wv));
      write_cfg(REG_IMAGE_HEIGHT, {CFG_W'($urandom_range(0, 511)) << DIM_W} | CFG_W'(hv));
      write_cfg(REG_EPS_SCALED, ev);
      if ($urandom_range(0, 5) == 0) write_cfg(REG_SPARE, CFG_W'($urandom));
      w = (wv < 3) ? 3 : int'(wv);
      h = (hv < 3) ? 3 : int'(hv);
      n = w * h;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n - 1);
      else n = n * $urandom_range(1, 2);
      if (n > RANDOM_PIXELS - random_pixels) n = RANDOM_PIXELS - random_pixels;
      if ($urandom_range(0, 3) == 0) begin
        // epsilon changes in the middle of a frame without restarting it
        feed_pixels(n / 2);
        wait_idle();
        write_cfg(REG_EPS_SCALED, EPS_W'($urandom));
        feed_pixels(n - n / 2);
      end else begin
        feed_pixels(n);
      end
      random_pixels += n;
    end

    // width above the limit clamps to 1024: a short stretch of row 0 stays silent
    idling = 1'b1;
    wait_idle();
    write_cfg(REG_IMAGE_WIDTH, '1);
    write_cfg(REG_IMAGE_HEIGHT, '0);
    write_cfg(REG_EPS_SCALED, EPS_W'($urandom));
    feed_pixels(EDGE_PIXELS);

    // height above the limit clamps to 1024 rows: no bottom mirroring early on
    wait_idle();
    write_cfg(REG_IMAGE_WIDTH, CFG_W'(2));
    write_cfg(REG_IMAGE_HEIGHT, '1);
    feed_pixels(EDGE_PIXELS);

    wait_idle();
    repeat (40) @(posedge clk);

    $display("covered %0d pixel beats and %0d result beats over %0d complete frames",
             sb.pixels_seen, sb.results_ok + sb.mismatches, frames_seen);
    $display("%0d register writes, widths and heights clamped from below and above",
             writes_done);
    if (sb.outstanding() != 0)
      $display("%0d expected results never arrived", sb.outstanding());
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching result beats", sb.mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### local_rgb_mean_covariance_3x3.f
+incdir+rtl/core
rtl/core/lrmc_pkg.sv
rtl/core/local_rgb_mean_covariance_3x3.sv
tb/tb.sv
